/* hw/rtl/rps_pkg.sv */
// rps_pkg: widths, microcode step codes, control word layout and the control rom
// of the shuffle block. no dependencies; the core, divider, sequencer and tb import it.
package rps_pkg;

  // sizing
  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned ELEMENT_BITS = 32;
  localparam int unsigned RAND_BITS    = 31;

  localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned PC_W  = 4;

  localparam logic [RAND_BITS-1:0] RAND_FULL = '1;
  localparam logic [CNT_W-1:0]     MAX_CNT   = CNT_W'(MAX_ELEMENTS);

  // microcode step addresses
  localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHK   = 4'd1;
  localparam logic [PC_W-1:0] STEP_DIV1  = 4'd2;
  localparam logic [PC_W-1:0] STEP_WAIT1 = 4'd3;
  localparam logic [PC_W-1:0] STEP_DIV2  = 4'd4;
  localparam logic [PC_W-1:0] STEP_WAIT2 = 4'd5;
  localparam logic [PC_W-1:0] STEP_RDJ   = 4'd6;
  localparam logic [PC_W-1:0] STEP_RDI   = 4'd7;
  localparam logic [PC_W-1:0] STEP_WRJ   = 4'd8;
  localparam logic [PC_W-1:0] STEP_WRI   = 4'd9;
  localparam logic [PC_W-1:0] STEP_OCLR  = 4'd10;
  localparam logic [PC_W-1:0] STEP_ORD   = 4'd11;
  localparam logic [PC_W-1:0] STEP_OEM   = 4'd12;
  localparam logic [PC_W-1:0] STEP_DONE  = 4'd13;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_WAIT_GO,
    COND_DIV_BUSY,
    COND_LOOP_END,
    COND_OUT_MORE
  } cond_e;

  // one control word per step
  typedef struct packed {
    logic            rd_rand;
    logic            div_start;
    logic            div_second;
    logic            elem_rd;
    logic            rd_at_j;
    logic            wr_en;
    logic            wr_at_i;
    logic            cap_tmp;
    logic            clr_i;
    logic            inc_i;
    logic            emit;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // status fed back to the sequencer
  typedef struct packed {
    logic go;
    logic div_busy;
    logic loop_end;
    logic out_more;
  } seq_status_t;

  // control rom
  function automatic ctrl_word_t rom_word(logic [PC_W-1:0] pc);
    ctrl_word_t w;
    w = '0;
    w.cond   = COND_NEVER;
    w.target = STEP_IDLE;
    case (pc)
      STEP_IDLE: begin
        w.clr_i  = 1'b1;
        w.cond   = COND_WAIT_GO;
        w.target = STEP_IDLE;
      end
      STEP_CHK: begin
        w.rd_rand = 1'b1;
        w.cond    = COND_LOOP_END;
        w.target  = STEP_OCLR;
      end
      STEP_DIV1: begin
        w.div_start = 1'b1;
      end
      STEP_WAIT1: begin
        w.cond   = COND_DIV_BUSY;
        w.target = STEP_WAIT1;
      end
      STEP_DIV2: begin
        w.div_start  = 1'b1;
        w.div_second = 1'b1;
      end
      STEP_WAIT2: begin
        w.cond   = COND_DIV_BUSY;
        w.target = STEP_WAIT2;
      end
      STEP_RDJ: begin
        w.elem_rd = 1'b1;
        w.rd_at_j = 1'b1;
      end
      STEP_RDI: begin
        w.elem_rd = 1'b1;
        w.cap_tmp = 1'b1;
      end
      STEP_WRJ: begin
        w.wr_en = 1'b1;
      end
      STEP_WRI: begin
        w.wr_en   = 1'b1;
        w.wr_at_i = 1'b1;
        w.inc_i   = 1'b1;
        w.cond    = COND_ALWAYS;
        w.target  = STEP_CHK;
      end
      STEP_OCLR: begin
        w.clr_i = 1'b1;
      end
      STEP_ORD: begin
        w.elem_rd = 1'b1;
      end
      STEP_OEM: begin
        w.emit   = 1'b1;
        w.inc_i  = 1'b1;
        w.cond   = COND_OUT_MORE;
        w.target = STEP_ORD;
      end
      STEP_DONE: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/random_permutation_shuffle_core.sv */
// random_permutation_shuffle_core: top level, datapath around the stores.
// depends on rps_pkg, rps_ram, rps_divider and rps_sequencer.
//
// usage: present one element with its random word and pulse start while busy
// is low; each such cycle stores one item (up to MAX_ELEMENTS items, later
// ones are dropped). an item with last_item_i set closes the set of n
// elements and raises busy for the shuffle pass.
// each swap position runs two restoring divisions on the shared divider,
// each followed by a wait for it to finish, plus seven microcode steps for
// the loop test, the divider starts and the store reads and writes. the
// emit phase reads the element store once per result. with n <= 1 the
// swap loop is skipped.
// results come out on element_out_o and last_out_o, each valid for exactly
// one cycle while strobe_o is high; last_out_o marks the final one. the
// receiver cannot hold results off. reset clears the fill count and the
// sequencer; the stores hold no meaningful contents until written.
module random_permutation_shuffle_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] element_value_i,
  input  logic [30:0] random_word_i,
  input  logic        last_item_i,
  output logic        strobe_o,
  output logic [31:0] element_out_o,
  output logic        last_out_o
);
  import rps_pkg::*;

  ctrl_word_t  ctrl;
  seq_status_t status;
  logic        seq_busy;
  logic        accept;
  logic        load_we;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] i_inc;
  logic [ELEMENT_BITS-1:0] tmp_q;

  logic                    div_busy;
  logic [RAND_BITS-1:0]    quotient;
  logic [RAND_BITS-1:0]    div_dividend;
  logic [RAND_BITS-1:0]    div_divisor;
  logic [RAND_BITS-1:0]    rand_rdata;
  logic [ELEMENT_BITS-1:0] elem_rdata;

  logic [RAND_BITS:0] j_sum;
  logic [CNT_W-1:0]   j_cnt;
  logic [IDX_W-1:0]   j_idx;
  logic [IDX_W-1:0]   i_idx;

  logic                    elem_we;
  logic [IDX_W-1:0]        elem_waddr;
  logic [ELEMENT_BITS-1:0] elem_wdata;
  logic [IDX_W-1:0]        elem_raddr;

  // load handshake
  assign accept  = start && !seq_busy;
  assign load_we = accept && (count_q < MAX_CNT);

  assign i_inc = i_q + 1'b1;
  assign i_idx = i_q[IDX_W-1:0];

  // fill count, set size and position counter
  always_comb begin
    count_d = count_q;
    n_d     = n_q;
    i_d     = i_q;
    if (accept) begin
      count_d = load_we ? count_q + 1'b1 : count_q;
      if (last_item_i) begin
        n_d     = count_d;
        count_d = '0;
      end
    end
    if (ctrl.clr_i) begin
      i_d = '0;
    end else if (ctrl.inc_i) begin
      i_d = i_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      n_q     <= '0;
      i_q     <= '0;
    end else begin
      count_q <= count_d;
      n_q     <= n_d;
      i_q     <= i_d;
    end
  end

  // swap partner held in tmp between read and write back
  always_ff @(posedge clk_i) begin
    if (ctrl.cap_tmp) begin
      tmp_q <= elem_rdata;
    end
  end

  // divider operands: first full scale / span, then r / (quotient + 1)
  always_comb begin
    if (ctrl.div_second) begin
      div_dividend = rand_rdata;
      div_divisor  = quotient + 1'b1;
    end else begin
      div_dividend = RAND_FULL;
      div_divisor  = RAND_BITS'(n_q - i_q);
    end
  end

  // swap index, clamped to the last position
  always_comb begin
    j_sum = (RAND_BITS + 1)'(i_q) + (RAND_BITS + 1)'(quotient);
    j_cnt = (j_sum >= (RAND_BITS + 1)'(n_q)) ? n_q - 1'b1 : CNT_W'(j_sum);
    j_idx = j_cnt[IDX_W-1:0];
  end

  // element store port muxing
  always_comb begin
    if (!seq_busy) begin
      elem_we    = load_we;
      elem_waddr = count_q[IDX_W-1:0];
      elem_wdata = ELEMENT_BITS'(element_value_i);
    end else begin
      elem_we    = ctrl.wr_en;
      elem_waddr = ctrl.wr_at_i ? i_idx : j_idx;
      elem_wdata = ctrl.wr_at_i ? tmp_q : elem_rdata;
    end
    elem_raddr = ctrl.rd_at_j ? j_idx : i_idx;
  end

  // status back to the sequencer
  always_comb begin
    status.go       = accept && last_item_i;
    status.div_busy = div_busy;
    status.loop_end = i_inc >= n_q;
    status.out_more = i_inc != n_q;
  end

  rps_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (seq_busy)
  );

  rps_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  rps_ram #(
    .DATA_W (ELEMENT_BITS),
    .ADDR_W (IDX_W)
  ) u_elem_store (
    .clk_i   (clk_i),
    .we_i    (elem_we),
    .waddr_i (elem_waddr),
    .wdata_i (elem_wdata),
    .re_i    (ctrl.elem_rd),
    .raddr_i (elem_raddr),
    .rdata_o (elem_rdata)
  );

  rps_ram #(
    .DATA_W (RAND_BITS),
    .ADDR_W (IDX_W)
  ) u_rand_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (RAND_BITS'(random_word_i)),
    .re_i    (ctrl.rd_rand),
    .raddr_i (i_idx),
    .rdata_o (rand_rdata)
  );

  // result ports
  assign busy          = seq_busy;
  assign strobe_o      = ctrl.emit;
  assign element_out_o = 32'(elem_rdata);
  assign last_out_o    = ctrl.emit && !status.out_more;

endmodule

/* hw/rtl/rps_ram.sv */
// rps_ram: generic single-write, single-read memory with registered read data.
// no package dependency; sized by its parameters.
module rps_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rps_divider.sv */
// rps_divider: restoring divider, one quotient bit per cycle.
// depends on rps_pkg for RAND_BITS.
module rps_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rps_pkg::RAND_BITS-1:0] dividend_i,
  input  logic [rps_pkg::RAND_BITS-1:0] divisor_i,
  output logic                          busy_o,
  output logic [rps_pkg::RAND_BITS-1:0] quotient_o
);
  import rps_pkg::*;

  localparam int unsigned STEP_CW = $clog2(RAND_BITS + 1);

  logic [STEP_CW-1:0]   cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [RAND_BITS-1:0] rem_q, rem_d;
  logic [RAND_BITS-1:0] quo_q, quo_d;
  logic [RAND_BITS-1:0] dvs_q, dvs_d;
  logic [RAND_BITS:0]   shifted;
  logic [RAND_BITS:0]   diff;
  logic                 ge;

  // one shift-subtract step
  always_comb begin
    shifted = {rem_q, quo_q[RAND_BITS-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = STEP_CW'(RAND_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[RAND_BITS-1:0] : shifted[RAND_BITS-1:0];
      quo_d = {quo_q[RAND_BITS-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

/* hw/rtl/rps_sequencer.sv */
// rps_sequencer: step counter over the control rom with conditional jumps.
// depends on rps_pkg for the rom, control word and status types.
module rps_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rps_pkg::seq_status_t status_i,
  output rps_pkg::ctrl_word_t  ctrl_o,
  output logic                 busy_o
);
  import rps_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_word_t      word;
  logic            take;

  // fetch and branch decision
  always_comb begin
    word = rom_word(pc_q);
    case (word.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_WAIT_GO:  take = !status_i.go;
      COND_DIV_BUSY: take = status_i.div_busy;
      COND_LOOP_END: take = status_i.loop_end;
      COND_OUT_MORE: take = status_i.out_more;
      default:       take = 1'b1;
    endcase
    pc_d = take ? word.target : pc_q + 1'b1;
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word;
  assign busy_o = pc_q != STEP_IDLE;

endmodule

/* hw/rtl/rps_checker.sv */
// rps_checker: port-level assertions for the shuffle block, bound to the top.
// depends on random_permutation_shuffle_core port names.
module rps_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_item_i,
  input logic strobe_o,
  input logic last_out_o
);

  // results appear only inside a pass
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy)
    else $error("result strobe outside a pass");

  // end marker only on a result
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_out_o |-> strobe_o)
    else $error("last marker without a result");

  // an item without the last flag does not start a pass
  a_no_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_item_i) |=> !busy)
    else $error("pass started without a last item");

  // an item with the last flag starts a pass
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_item_i) |=> busy)
    else $error("last item did not start a pass");

  // nothing follows the final result
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_out_o) |=> !strobe_o)
    else $error("result after the final one");

endmodule

bind random_permutation_shuffle_core rps_checker u_rps_checker (.*);

/* test/tb.sv */
// tb: self-checking testbench for random_permutation_shuffle_core.
// depends on rps_pkg and the core; holds its own shuffle predictor and
// checks every emitted item in order against it.
module tb;
  import rps_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 90;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned N_DIR        = 20;

  // one stimulus row; exp_a/exp_b hold typed results for sets of one or two
  typedef struct packed {
    logic [31:0] elem;
    logic [30:0] rnd;
    logic        last;
    logic        typed;
    logic [31:0] exp_a;
    logic [31:0] exp_b;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] elem;
    logic        last;
  } perm_out_t;

  // directed rows: single sets, pair sets around the swap threshold, larger sets
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    '{32'hA5A5A5A5, 31'h00000000, 1'b1, 1'b1, 32'hA5A5A5A5, 32'h0},
    '{32'hFFFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 32'h0},
    '{32'h00000000, 31'h2AAAAAAA, 1'b1, 1'b1, 32'h00000000, 32'h0},
    '{32'h00000001, 31'h00000000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'h80000000, 31'h7FFFFFFF, 1'b1, 1'b1, 32'h00000001, 32'h80000000},
    '{32'h12345678, 31'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'h9ABCDEF0, 31'h00000000, 1'b1, 1'b1, 32'h9ABCDEF0, 32'h12345678},
    '{32'h11111111, 31'h3FFFFFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'h22222222, 31'h00000000, 1'b1, 1'b1, 32'h11111111, 32'h22222222},
    '{32'h33333333, 31'h40000000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'h44444444, 31'h55555555, 1'b1, 1'b1, 32'h44444444, 32'h33333333},
    '{32'h000000A0, 31'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'h000000A1, 31'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'h000000A2, 31'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'h000000A3, 31'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'h000000A4, 31'h7FFFFFFF, 1'b1, 1'b0, 32'h0, 32'h0},
    '{32'hFFFFFFFF, 31'h00000000, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'h00000000, 31'h7FFFFFFF, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'h5555AAAA, 31'h2AAAAAAA, 1'b0, 1'b0, 32'h0, 32'h0},
    '{32'hAAAA5555, 31'h55555555, 1'b1, 1'b0, 32'h0, 32'h0}
  };

  localparam int unsigned IDLE_PCTS [3] = '{0, 48, 7};

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start           = 1'b0;
  logic        busy;
  logic [31:0] element_value_i = '0;
  logic [30:0] random_word_i   = '0;
  logic        last_item_i     = 1'b0;
  logic        strobe_o;
  logic [31:0] element_out_o;
  logic        last_out_o;

  // predictor state: the set being loaded
  logic [31:0] set_elems [MAX_ELEMENTS];
  logic [30:0] set_rands [MAX_ELEMENTS];
  int unsigned set_len      = 0;
  int unsigned stored_cnt   = 0;
  int unsigned idle_pct     = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  perm_out_t   permuted_q [$];

  random_permutation_shuffle_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .element_value_i(element_value_i),
    .random_word_i  (random_word_i),
    .last_item_i    (last_item_i),
    .strobe_o       (strobe_o),
    .element_out_o  (element_out_o),
    .last_out_o     (last_out_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still pending", cycle_cnt,
               permuted_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_cnt < 50) $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    mismatch_cnt++;
  endtask

  // fisher-yates pass over the first n loaded elements
  function automatic void permute_set(input int unsigned n);
    longint unsigned rmax;
    longint unsigned divisor;
    longint unsigned j;
    logic [31:0]     tmp;
    rmax = (64'd1 << RAND_BITS) - 1;
    for (int unsigned i = 0; i + 1 < n; i++) begin
      divisor = rmax / longint'(n - i) + 1;
      j = longint'(i) + longint'(set_rands[i]) / divisor;
      // guard, never hit for any legal random word
      if (j >= n) j = n - 1;
      tmp          = set_elems[j];
      set_elems[j] = set_elems[i];
      set_elems[i] = tmp;
    end
  endfunction

  // update the predictor with one accepted item
  task automatic accept_item(input stim_row_t row);
    perm_out_t   res;
    int unsigned n;
    if (set_len < MAX_ELEMENTS) begin
      set_elems[set_len] = row.elem;
      set_rands[set_len] = row.rnd;
      set_len++;
      stored_cnt++;
    end
    if (row.last) begin
      n = set_len;
      permute_set(n);
      for (int unsigned k = 0; k < n; k++) begin
        res.elem = set_elems[k];
        if (row.typed) res.elem = (k == 0) ? row.exp_a : row.exp_b;
        res.last = (k + 1 == n);
        permuted_q.push_back(res);
      end
      set_len = 0;
    end
  endtask

  // drive one item from a falling edge, wait for acceptance, return at a falling edge
  task automatic send_item(input stim_row_t row);
    while ($urandom_range(0, 99) < idle_pct) begin
      start           <= 1'b0;
      element_value_i <= $urandom;
      random_word_i   <= 31'($urandom);
      last_item_i     <= 1'($urandom);
      @(negedge clk_i);
    end
    start           <= 1'b1;
    element_value_i <= row.elem;
    random_word_i   <= row.rnd;
    last_item_i     <= row.last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    accept_item(row);
    @(negedge clk_i);
  endtask

  // one set of random content; the final item carries the last flag
  task automatic run_set(input int unsigned n_items);
    stim_row_t row;
    for (int unsigned k = 0; k < n_items; k++) begin
      row = '0;
      case ($urandom_range(0, 9))
        0:       row.elem = '1;
        1:       row.elem = '0;
        default: row.elem = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       row.rnd = '1;
        1:       row.rnd = '0;
        default: row.rnd = 31'($urandom);
      endcase
      row.last = (k + 1 == n_items);
      send_item(row);
    end
  endtask

  // result check against the oldest pending item
  always @(posedge clk_i) begin : result_check
    perm_out_t want;
    if (rst_ni && strobe_o) begin
      if (permuted_q.size() == 0) begin
        report_mismatch($sformatf("item %h with nothing pending", element_out_o));
      end else begin
        want = permuted_q.pop_front();
        if (element_out_o !== want.elem)
          report_mismatch($sformatf("element %h, want %h", element_out_o, want.elem));
        if (last_out_o !== want.last)
          report_mismatch($sformatf("last flag %b, want %b", last_out_o, want.last));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned set_idx;
    int unsigned n_items;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    idle_pct = 0;
    for (int unsigned r = 0; r < N_DIR; r++) send_item(DIR_ROWS[r]);

    // random part: one overflowing set first, then mostly small sets
    stored_cnt = 0;
    set_idx    = 0;
    while (stored_cnt < RANDOM_ITEMS) begin
      idle_pct = IDLE_PCTS[set_idx % 3];
      if (set_idx == 0) n_items = MAX_ELEMENTS + $urandom_range(1, 3);
      else if ($urandom_range(0, 9) == 0) n_items = $urandom_range(9, 20);
      else n_items = $urandom_range(1, 6);
      run_set(n_items);
      set_idx++;
    end
    start <= 1'b0;

    // drain
    while (permuted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/rps_pkg.sv
hw/rtl/rps_ram.sv
hw/rtl/rps_divider.sv
hw/rtl/rps_sequencer.sv
hw/rtl/random_permutation_shuffle_core.sv
hw/rtl/rps_checker.sv
test/tb.sv
